// File: rtl/core/rlhc_pkg.sv
// Shared types and constants for the RGB/luma histogram and clip statistics block.
// No dependencies.
package rlhc_pkg;

  localparam int BIN_INDEX_BITS  = 6;
  localparam int LEVEL_BITS      = 17;
  localparam int PCT_BITS        = 15;
  localparam int QUOT_BITS       = 17;
  localparam int LEVEL_FRAC_BITS = 16;
  localparam int PCT_SCALE       = 25600;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 8;

  localparam int NUM_CH  = 4;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_LUMA  = 3;

  localparam logic [15:0] LUMA_R_WT = 16'd77;
  localparam logic [15:0] LUMA_G_WT = 16'd150;
  localparam logic [15:0] LUMA_B_WT = 16'd29;

  localparam logic [7:0] CLIP_LOW_RESET  = 8'd5;
  localparam logic [7:0] CLIP_HIGH_RESET = 8'd250;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SWAP_RED_BLUE = 2'd0,
    CFG_CLIP_LOW      = 2'd1,
    CFG_CLIP_HIGH     = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    logic [BIN_INDEX_BITS-1:0] bin_index;
    logic [LEVEL_BITS-1:0]     red_level;
    logic [LEVEL_BITS-1:0]     green_level;
    logic [LEVEL_BITS-1:0]     blue_level;
    logic [LEVEL_BITS-1:0]     luma_level;
    logic [PCT_BITS-1:0]       shadow_clip_percent;
    logic [PCT_BITS-1:0]       highlight_clip_percent;
    logic                      last_bin;
  } result_t;

endpackage

// File: rtl/core/rgb_luma_histogram_clip_stats.sv
// Top level: red/green/blue/luma histograms with shadow and highlight clip counts.
// Uses rlhc_pkg, rlhc_ram (one per histogram) and rlhc_div (one per histogram).
//
// Usage:
//   pix channel: one pixel per beat (three bytes, frame_end on the frame's last
//   pixel). One pixel is taken every cycle while accumulating; each pixel does a
//   read-modify-write of one bin in each of four histogram RAMs, with the
//   previous cycle's write forwarded when both hit the same bin.
//   res channel: after the frame_end pixel, pix_ready drops and the block emits
//   BIN_COUNT beats, bins 0 up, last_bin set on the final one. The two clip
//   percentages are computed first; each bin then goes through a RAM read, the
//   per-histogram shift-subtract dividers, and the output load.
//   Bins are cleared as they are read out; totals and peak clear on the last bin.
//   cfg channel: always ready; write only while no frame is in flight.
//   Reset: registers take their reset values and a clearing pass writes zero to
//   every bin, with pix_ready low.
//   A stalled res_ready holds the current result; the next bin is computed
//   meanwhile and waits in the divider until the output register frees up.
module rgb_luma_histogram_clip_stats #(
  parameter int BIN_COUNT  = 64,
  parameter int COUNT_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  output logic                                pix_ready,
  input  rlhc_pkg::pixel_t                    pix,
  output logic                                res_valid,
  input  logic                                res_ready,
  output rlhc_pkg::result_t                   res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rlhc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rlhc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import rlhc_pkg::*;

  localparam int BIN_BITS  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int PROD_BITS = 8 + BIN_BITS;
  localparam int NUM_BITS  = COUNT_BITS + QUOT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [BIN_BITS-1:0]   LAST_BIN  = BIN_BITS'(BIN_COUNT - 1);

  typedef enum logic [7:0] {
    ST_CLR   = 8'b0000_0001,
    ST_ACC   = 8'b0000_0010,
    ST_PGO   = 8'b0000_0100,
    ST_PWAIT = 8'b0000_1000,
    ST_BRD   = 8'b0001_0000,
    ST_BLD   = 8'b0010_0000,
    ST_BWAIT = 8'b0100_0000,
    ST_BOUT  = 8'b1000_0000
  } state_t;

  function automatic logic [BIN_BITS-1:0] bin_of(input logic [7:0] v);
    logic [PROD_BITS-1:0] p;
    p = PROD_BITS'(v) * PROD_BITS'(BIN_COUNT);
    return p[PROD_BITS-1:8];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

  state_t state;
  logic [BIN_BITS-1:0] bin;

  logic       swap_red_blue;
  logic [7:0] clip_low_threshold;
  logic [7:0] clip_high_threshold;

  logic [COUNT_BITS-1:0] pixel_total;
  logic [COUNT_BITS-1:0] shadow_total;
  logic [COUNT_BITS-1:0] highlight_total;
  logic [COUNT_BITS-1:0] peak_count;
  logic [COUNT_BITS-1:0] peak_next;

  logic       pix_beat;
  logic [7:0] red, green, blue, luma;
  logic [15:0] luma_sum;
  logic [7:0] sample [NUM_CH];
  logic [BIN_BITS-1:0] s0_bin [NUM_CH];

  logic                  s1_vld;
  logic [BIN_BITS-1:0]   s1_bin [NUM_CH];
  logic                  wq_vld;
  logic [BIN_BITS-1:0]   wq_bin [NUM_CH];
  logic [COUNT_BITS-1:0] wq_data [NUM_CH];
  logic [COUNT_BITS-1:0] cur [NUM_CH];
  logic [COUNT_BITS-1:0] upd [NUM_CH];

  logic [NUM_CH-1:0]     ram_we;
  logic [BIN_BITS-1:0]   ram_waddr [NUM_CH];
  logic [COUNT_BITS-1:0] ram_wdata [NUM_CH];
  logic [BIN_BITS-1:0]   ram_raddr [NUM_CH];
  logic [COUNT_BITS-1:0] ram_rdata [NUM_CH];

  logic                  div_start;
  logic [NUM_CH-1:0]     div_busy;
  logic [NUM_BITS-1:0]   div_num [NUM_CH];
  logic [COUNT_BITS-1:0] div_den [NUM_CH];
  logic [QUOT_BITS-1:0]  div_quot [NUM_CH];

  logic [PCT_BITS-1:0] shadow_pct;
  logic [PCT_BITS-1:0] highlight_pct;
  logic                res_load;

  assign pix_ready = (state == ST_ACC);
  assign cfg_ready = 1'b1;
  assign pix_beat  = pix_valid && pix_ready;
  assign div_start = (state == ST_PGO) || (state == ST_BLD);
  assign res_load  = (state == ST_BOUT) && (!res_valid || res_ready);

  always_comb begin
    red      = swap_red_blue ? pix.third_byte : pix.first_byte;
    green    = pix.second_byte;
    blue     = swap_red_blue ? pix.first_byte : pix.third_byte;
    luma_sum = 16'(red) * LUMA_R_WT + 16'(green) * LUMA_G_WT + 16'(blue) * LUMA_B_WT;
    luma     = luma_sum[15:8];
    sample[CH_RED]   = red;
    sample[CH_GREEN] = green;
    sample[CH_BLUE]  = blue;
    sample[CH_LUMA]  = luma;
    for (int c = 0; c < NUM_CH; c++) begin
      s0_bin[c] = bin_of(sample[c]);
    end
  end

  // second stage: forward last cycle's write on a bin match
  always_comb begin
    peak_next = peak_count;
    for (int c = 0; c < NUM_CH; c++) begin
      cur[c] = (wq_vld && (wq_bin[c] == s1_bin[c])) ? wq_data[c] : ram_rdata[c];
      upd[c] = sat_inc(cur[c]);
      if (upd[c] > peak_next) begin
        peak_next = upd[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ram_raddr[c] = (state == ST_ACC) ? s0_bin[c] : bin;
      ram_we[c]    = s1_vld || (state == ST_CLR) || (state == ST_BLD);
      ram_waddr[c] = s1_vld ? s1_bin[c] : bin;
      ram_wdata[c] = s1_vld ? upd[c] : '0;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      div_num[c] = (NUM_BITS'(ram_rdata[c]) << LEVEL_FRAC_BITS) + NUM_BITS'(peak_count >> 1);
      div_den[c] = peak_count;
    end
    if (state == ST_PGO) begin
      div_num[CH_RED]   = NUM_BITS'(shadow_total) * NUM_BITS'(PCT_SCALE)
                        + NUM_BITS'(pixel_total >> 1);
      div_num[CH_GREEN] = NUM_BITS'(highlight_total) * NUM_BITS'(PCT_SCALE)
                        + NUM_BITS'(pixel_total >> 1);
      div_num[CH_BLUE]  = '0;
      div_num[CH_LUMA]  = '0;
      for (int c = 0; c < NUM_CH; c++) begin
        div_den[c] = pixel_total;
      end
    end
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
    rlhc_ram #(
      .WIDTH     (COUNT_BITS),
      .DEPTH     (BIN_COUNT),
      .ADDR_BITS (BIN_BITS)
    ) u_hist (
      .clk     (clk),
      .wr_en   (ram_we[g]),
      .wr_addr (ram_waddr[g]),
      .wr_data (ram_wdata[g]),
      .rd_addr (ram_raddr[g]),
      .rd_data (ram_rdata[g])
    );

    rlhc_div #(
      .DEN_BITS  (COUNT_BITS),
      .QUOT_BITS (QUOT_BITS)
    ) u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (div_num[g]),
      .den   (div_den[g]),
      .busy  (div_busy[g]),
      .quot  (div_quot[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_CLR;
      bin                 <= '0;
      swap_red_blue       <= 1'b0;
      clip_low_threshold  <= CLIP_LOW_RESET;
      clip_high_threshold <= CLIP_HIGH_RESET;
      pixel_total         <= '0;
      shadow_total        <= '0;
      highlight_total     <= '0;
      peak_count          <= COUNT_BITS'(1);
      s1_vld              <= 1'b0;
      wq_vld              <= 1'b0;
      res_valid           <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SWAP_RED_BLUE: swap_red_blue       <= cfg_data[0];
          CFG_CLIP_LOW:      clip_low_threshold  <= cfg_data;
          CFG_CLIP_HIGH:     clip_high_threshold <= cfg_data;
          default: ;
        endcase
      end

      s1_vld <= pix_beat;
      wq_vld <= s1_vld;
      if (pix_beat) begin
        pixel_total <= sat_inc(pixel_total);
        if (luma <= clip_low_threshold) begin
          shadow_total <= sat_inc(shadow_total);
        end
        if (luma >= clip_high_threshold) begin
          highlight_total <= sat_inc(highlight_total);
        end
      end
      if (s1_vld) begin
        peak_count <= peak_next;
      end

      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_CLR: begin
          if (bin == LAST_BIN) begin
            bin   <= '0;
            state <= ST_ACC;
          end else begin
            bin <= bin + BIN_BITS'(1);
          end
        end
        ST_ACC: begin
          if (pix_beat && pix.frame_end) begin
            state <= ST_PGO;
          end
        end
        ST_PGO:   state <= ST_PWAIT;
        ST_PWAIT: begin
          if (div_busy == '0) begin
            state <= ST_BRD;
          end
        end
        ST_BRD:   state <= ST_BLD;
        ST_BLD:   state <= ST_BWAIT;
        ST_BWAIT: begin
          if (div_busy == '0) begin
            state <= ST_BOUT;
          end
        end
        ST_BOUT: begin
          if (res_load) begin
            if (bin == LAST_BIN) begin
              bin             <= '0;
              pixel_total     <= '0;
              shadow_total    <= '0;
              highlight_total <= '0;
              peak_count      <= COUNT_BITS'(1);
              state           <= ST_ACC;
            end else begin
              bin   <= bin + BIN_BITS'(1);
              state <= ST_BRD;
            end
          end
        end
        default: state <= ST_CLR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pix_beat) begin
      s1_bin <= s0_bin;
    end
    wq_bin  <= s1_bin;
    wq_data <= upd;
    if ((state == ST_PWAIT) && (div_busy == '0)) begin
      shadow_pct    <= div_quot[CH_RED][PCT_BITS-1:0];
      highlight_pct <= div_quot[CH_GREEN][PCT_BITS-1:0];
    end
    if (res_load) begin
      res.bin_index              <= BIN_INDEX_BITS'(bin);
      res.red_level              <= div_quot[CH_RED];
      res.green_level            <= div_quot[CH_GREEN];
      res.blue_level             <= div_quot[CH_BLUE];
      res.luma_level             <= div_quot[CH_LUMA];
      res.shadow_clip_percent    <= shadow_pct;
      res.highlight_clip_percent <= highlight_pct;
      res.last_bin               <= (bin == LAST_BIN);
    end
  end

endmodule

// File: rtl/core/rlhc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rlhc_ram #(
  parameter int WIDTH     = 20,
  parameter int DEPTH     = 64,
  parameter int ADDR_BITS = 6
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/rlhc_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// Needs numerator >> QUOT_BITS below the divisor. No dependencies.
module rlhc_div #(
  parameter int DEN_BITS  = 20,
  parameter int QUOT_BITS = 17
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DEN_BITS+QUOT_BITS-1:0] num,
  input  logic [DEN_BITS-1:0]           den,
  output logic                          busy,
  output logic [QUOT_BITS-1:0]          quot
);

  localparam int CNT_BITS = $clog2(QUOT_BITS + 1);

  logic [DEN_BITS-1:0]  rem;
  logic [DEN_BITS-1:0]  den_q;
  logic [QUOT_BITS-1:0] qsr;
  logic [CNT_BITS-1:0]  cnt;
  logic [DEN_BITS:0]    trial;
  logic                 fits;

  assign trial = {rem, qsr[QUOT_BITS-1]};
  assign fits  = (trial >= {1'b0, den_q});
  assign quot  = qsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_BITS'(QUOT_BITS);
    end else if (busy) begin
      cnt <= cnt - CNT_BITS'(1);
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[DEN_BITS+QUOT_BITS-1:QUOT_BITS];
      qsr   <= num[QUOT_BITS-1:0];
      den_q <= den;
    end else if (busy) begin
      rem <= fits ? DEN_BITS'(trial - {1'b0, den_q}) : trial[DEN_BITS-1:0];
      qsr <= {qsr[QUOT_BITS-2:0], fits};
    end
  end

endmodule

// File: rtl/core/rlhc_checker.sv
// Port-level checks for rgb_luma_histogram_clip_stats, attached by bind.
// Uses rlhc_pkg.
module rlhc_checker #(
  parameter int BIN_COUNT = 64
) (
  input logic              clk,
  input logic              rst,
  input logic              pix_valid,
  input logic              pix_ready,
  input rlhc_pkg::pixel_t  pix,
  input logic              res_valid,
  input logic              res_ready,
  input rlhc_pkg::result_t res
);

  import rlhc_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid && !pix_ready)
    else $error("outputs active right after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_frame_end_closes: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && pix.frame_end |=> !pix_ready)
    else $error("pixel input still open after frame end");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last_bin |-> res.bin_index == BIN_INDEX_BITS'(BIN_COUNT - 1))
    else $error("last_bin on wrong bin");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res.last_bin |=> !res_valid)
    else $error("result beat after last bin");

endmodule

bind rgb_luma_histogram_clip_stats rlhc_checker #(
  .BIN_COUNT (BIN_COUNT)
) u_rlhc_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix_valid),
  .pix_ready (pix_ready),
  .pix       (pix),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

// File: verif/rgb_luma_histogram_clip_stats_test.sv
// Self-checking bench for rgb_luma_histogram_clip_stats: frames of pixels in, per-bin levels out.
// A built-in predictor keeps its own histograms and clip totals; needs rlhc_pkg and the RTL.
`timescale 1ns / 100ps

module rgb_luma_histogram_clip_stats_test;
  import rlhc_pkg::*;

  localparam int BINS = 64;
  localparam int COUNT_BITS = 20;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int MAX_GAP = 14;
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_PIXELS = 200;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic pix_valid;
  logic pix_ready;
  pixel_t pix;
  logic res_valid;
  logic res_ready;
  result_t res;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  rgb_luma_histogram_clip_stats #(
    .BIN_COUNT (BINS),
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor state
  logic [COUNT_BITS-1:0] hist [NUM_CH][BINS];
  logic [COUNT_BITS-1:0] pixel_total;
  logic [COUNT_BITS-1:0] shadow_total;
  logic [COUNT_BITS-1:0] highlight_total;
  logic [COUNT_BITS-1:0] peak_count;
  logic swap_rb;
  logic [7:0] clip_low;
  logic [7:0] clip_high;
  result_t pending_bins[$];

  bit send_steady;
  bit take_steady;
  int pixels_sent;
  int frames_sent;
  int bins_checked;
  int reg_writes;
  int mismatches;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("rgb_luma_histogram_clip_stats_test failed");
    $finish;
  end

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

  function void clear_stats();
    for (int c = 0; c < NUM_CH; c++)
      for (int b = 0; b < BINS; b++)
        hist[c][b] = '0;
    pixel_total = '0;
    shadow_total = '0;
    highlight_total = '0;
    peak_count = COUNT_BITS'(1);
  endfunction

  function void count_into(input int ch, input int value);
    int b;
    b = ((value & 255) * BINS) >> 8;
    if (b > BINS - 1) b = BINS - 1;
    hist[ch][b] = sat_inc(hist[ch][b]);
    if (hist[ch][b] > peak_count) peak_count = hist[ch][b];
  endfunction

  function logic [LEVEL_BITS-1:0] level_of_count(input logic [COUNT_BITS-1:0] c);
    longint unsigned cl;
    longint unsigned pk;
    longint unsigned v;
    cl = c;
    pk = peak_count;
    v = (cl * 65536 + pk / 2) / pk;
    if (v > 65536) v = 65536;
    return v[LEVEL_BITS-1:0];
  endfunction

  function logic [PCT_BITS-1:0] clip_percent(input logic [COUNT_BITS-1:0] clipped);
    longint unsigned cl;
    longint unsigned tot;
    longint unsigned v;
    cl = clipped;
    tot = pixel_total;
    v = (cl * PCT_SCALE + tot / 2) / tot;
    if (v > PCT_SCALE) v = PCT_SCALE;
    return v[PCT_BITS-1:0];
  endfunction

  function void tally_pixel(input pixel_t p);
    int r;
    int g;
    int b;
    int luma;
    logic [PCT_BITS-1:0] sh;
    logic [PCT_BITS-1:0] hl;
    result_t e;
    r = swap_rb ? p.third_byte : p.first_byte;
    g = p.second_byte;
    b = swap_rb ? p.first_byte : p.third_byte;
    luma = (r * int'(LUMA_R_WT) + g * int'(LUMA_G_WT) + b * int'(LUMA_B_WT)) >> 8;
    count_into(CH_RED, r);
    count_into(CH_GREEN, g);
    count_into(CH_BLUE, b);
    count_into(CH_LUMA, luma);
    if (luma <= int'(clip_low)) shadow_total = sat_inc(shadow_total);
    if (luma >= int'(clip_high)) highlight_total = sat_inc(highlight_total);
    pixel_total = sat_inc(pixel_total);
    if (!p.frame_end) return;
    sh = clip_percent(shadow_total);
    hl = clip_percent(highlight_total);
    for (int i = 0; i < BINS; i++) begin
      e.bin_index = BIN_INDEX_BITS'(i);
      e.red_level = level_of_count(hist[CH_RED][i]);
      e.green_level = level_of_count(hist[CH_GREEN][i]);
      e.blue_level = level_of_count(hist[CH_BLUE][i]);
      e.luma_level = level_of_count(hist[CH_LUMA][i]);
      e.shadow_clip_percent = sh;
      e.highlight_clip_percent = hl;
      e.last_bin = (i == BINS - 1);
      pending_bins.push_back(e);
    end
    clear_stats();
    frames_sent++;
  endfunction

  function void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                          input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_SWAP_RED_BLUE: swap_rb = data[0];
      CFG_CLIP_LOW:      clip_low = data;
      CFG_CLIP_HIGH:     clip_high = data;
      default: ;
    endcase
  endfunction

  function int gap_draw(input bit steady);
    if (steady) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function pixel_t make_pixel(input int b0, input int b1, input int b2, input bit last);
    pixel_t p;
    p.first_byte = b0[7:0];
    p.second_byte = b1[7:0];
    p.third_byte = b2[7:0];
    p.frame_end = last;
    return p;
  endfunction

  function pixel_t random_pixel();
    return make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), 1'b0);
  endfunction

  function logic [7:0] pick_threshold();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task send_pixel(input pixel_t p);
    int gap;
    gap = gap_draw(send_steady);
    @(negedge clk);
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix <= p;
    pix_valid <= 1'b1;
    do @(posedge clk); while (!pix_ready);
    pixels_sent++;
    tally_pixel(p);
  endtask

  task write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending, let every pending bin drain, then let the pipeline settle
  task wait_readout_done();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task test_reset_defaults();
    send_pixel(make_pixel(0, 0, 0, 1'b1));
    send_pixel(make_pixel(255, 255, 255, 1'b1));
  endtask

  task test_clip_thresholds();
    send_pixel(make_pixel(5, 5, 5, 1'b0));
    send_pixel(make_pixel(6, 6, 6, 1'b0));
    send_pixel(make_pixel(249, 249, 249, 1'b0));
    send_pixel(make_pixel(250, 250, 250, 1'b1));
    wait_readout_done();
    // crossed thresholds: every pixel is both shadow and highlight
    write_reg(CFG_CLIP_LOW, 8'd255);
    write_reg(CFG_CLIP_HIGH, 8'd0);
    send_pixel(make_pixel(0, 0, 0, 1'b0));
    send_pixel(make_pixel(255, 255, 255, 1'b1));
    wait_readout_done();
    write_reg(CFG_CLIP_LOW, 8'd0);
    write_reg(CFG_CLIP_HIGH, 8'd255);
    send_pixel(make_pixel(0, 0, 0, 1'b0));
    send_pixel(make_pixel(1, 1, 1, 1'b0));
    send_pixel(make_pixel(255, 255, 255, 1'b1));
    wait_readout_done();
  endtask

  task test_byte_order();
    write_reg(CFG_SWAP_RED_BLUE, 8'd1);
    send_pixel(make_pixel(10, 20, 200, 1'b0));
    send_pixel(make_pixel(255, 0, 0, 1'b1));
    wait_readout_done();
    write_reg(CFG_SWAP_RED_BLUE, 8'd0);
    send_pixel(make_pixel(255, 0, 0, 1'b1));
    wait_readout_done();
  endtask

  // back-to-back beats landing in the same bins
  task test_same_bin_run();
    send_steady = 1'b1;
    for (int n = 0; n < 6; n++)
      send_pixel(make_pixel(128 + n % 4, 64 + n % 2, 32, n == 5));
    send_steady = 1'b0;
    wait_readout_done();
  endtask

  task test_unknown_register();
    write_reg(CFG_CLIP_LOW, CLIP_LOW_RESET);
    write_reg(CFG_CLIP_HIGH, CLIP_HIGH_RESET);
    write_reg(CFG_UNUSED, 8'd0);
    send_pixel(make_pixel(3, 3, 3, 1'b1));
    wait_readout_done();
  endtask

  task test_random_frames();
    int goal;
    int len;
    int frame_no;
    pixel_t palette [3];
    pixel_t p;
    goal = pixels_sent + RANDOM_PIXELS;
    frame_no = 0;
    while (pixels_sent < goal) begin
      if ($urandom_range(0, 3) == 0 || frame_no == 5) begin
        wait_readout_done();
        write_reg(CFG_SWAP_RED_BLUE, CFG_DATA_BITS'($urandom_range(0, 255)));
        write_reg(CFG_CLIP_LOW, pick_threshold());
        write_reg(CFG_CLIP_HIGH, pick_threshold());
        if ($urandom_range(0, 3) == 0)
          write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom_range(0, 255)));
      end
      send_steady = ($urandom_range(0, 3) == 0);
      take_steady = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      for (int k = 0; k < 3; k++) palette[k] = random_pixel();
      for (int n = 0; n < len; n++) begin
        p = $urandom_range(0, 1) ? palette[$urandom_range(0, 2)] : random_pixel();
        p.frame_end = (n == len - 1);
        send_pixel(p);
      end
      frame_no++;
    end
    send_steady = 1'b0;
    take_steady = 1'b0;
  endtask

  // result side
  initial begin
    int stall;
    res_ready = 1'b0;
    forever begin
      stall = gap_draw(take_steady);
      @(negedge clk);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (res_valid !== 1'b1);
    end
  end

  task log_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at cycle %0d", what, cycles);
      $display("  exp bin %0d r %0d g %0d b %0d y %0d sh %0d hl %0d last %0d",
               want.bin_index, want.red_level, want.green_level, want.blue_level,
               want.luma_level, want.shadow_clip_percent, want.highlight_clip_percent,
               want.last_bin);
      $display("  got bin %0d r %0d g %0d b %0d y %0d sh %0d hl %0d last %0d",
               got.bin_index, got.red_level, got.green_level, got.blue_level,
               got.luma_level, got.shadow_clip_percent, got.highlight_clip_percent,
               got.last_bin);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && res_valid === 1'b1 && res_ready === 1'b1) begin
      if (pending_bins.size() == 0) begin
        log_mismatch("bin beat with nothing pending", '0, res);
      end else begin
        want = pending_bins.pop_front();
        bins_checked++;
        if (res.bin_index !== want.bin_index ||
            res.red_level !== want.red_level ||
            res.green_level !== want.green_level ||
            res.blue_level !== want.blue_level ||
            res.luma_level !== want.luma_level ||
            res.shadow_clip_percent !== want.shadow_clip_percent ||
            res.highlight_clip_percent !== want.highlight_clip_percent ||
            res.last_bin !== want.last_bin)
          log_mismatch("bin beat mismatch", want, res);
      end
    end
  end

  initial begin
    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_steady = 1'b0;
    take_steady = 1'b0;
    pixels_sent = 0;
    frames_sent = 0;
    bins_checked = 0;
    reg_writes = 0;
    mismatches = 0;
    swap_rb = 1'b0;
    clip_low = CLIP_LOW_RESET;
    clip_high = CLIP_HIGH_RESET;
    clear_stats();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    wait_readout_done();
    test_clip_thresholds();
    test_byte_order();
    test_same_bin_run();
    test_unknown_register();
    test_random_frames();
    wait_readout_done();

    $display("covered %0d pixels in %0d frames, %0d bin beats checked, %0d register writes",
             pixels_sent, frames_sent, bins_checked, reg_writes);
    if (mismatches == 0 && pending_bins.size() == 0) begin
      $display("rgb_luma_histogram_clip_stats_test passed");
    end else begin
      $display("rgb_luma_histogram_clip_stats_test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rlhc_pkg.sv
rtl/core/rlhc_ram.sv
rtl/core/rlhc_div.sv
rtl/core/rgb_luma_histogram_clip_stats.sv
rtl/core/rlhc_checker.sv
verif/rgb_luma_histogram_clip_stats_test.sv
